/* hdl/adf_pkg.sv */
// Shared types and constants for the advertising flags discovery filter.
`default_nettype none

package adf_pkg;

	// AD structure type and flag bits
	localparam logic [7:0] AD_TYPE_FLAGS = 8'h01;
	localparam logic [7:0] BIT_LIMITED   = 8'h01;
	localparam logic [7:0] BIT_GENERAL   = 8'h02;

	// Discovery modes; the last code is undefined and fails every report
	localparam logic [1:0] MODE_NONE    = 2'd0;
	localparam logic [1:0] MODE_LIMITED = 2'd1;
	localparam logic [1:0] MODE_GENERAL = 2'd2;
	localparam logic [1:0] MODE_UNKNOWN = 2'd3;

	// Walk position inside an LTV structure
	typedef enum logic [1:0] {
		PH_LEN       = 2'd0,
		PH_TYPE      = 2'd1,
		PH_VAL_FIRST = 2'd2,
		PH_VAL_REST  = 2'd3
	} phase_t;

	// One input transaction
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_byte;
	} item_t;

	// One verdict
	typedef struct packed {
		logic [7:0] flags_value;
		logic       flags_found;
		logic       report_pass;
	} result_t;

endpackage

`default_nettype wire

/* hdl/adf_in_stage.sv */
// Input register stage: captures one accepted transaction per cycle while it has room.
`default_nettype none

module adf_in_stage (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire adf_pkg::item_t in_item,
	input  wire logic          advance,
	output logic               valid_s1,
	output adf_pkg::item_t     item_s1
);

	// Room whenever the stage is empty or drains this cycle
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// Payload needs no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

`default_nettype wire

/* hdl/adf_walk.sv */
// LTV walk state, flags capture and verdict logic.
`default_nettype none

module adf_walk (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire adf_pkg::item_t item,
	input  wire logic [1:0]     mode,
	output logic                res_valid,
	output adf_pkg::result_t    res
);

	adf_pkg::phase_t phase_q, phase_d;
	logic [7:0] left_q, left_d;
	logic       is_flags_q, is_flags_d;
	logic [7:0] held_q, held_d;
	logic       seen_q, seen_d;
	logic       over_q, over_d;
	logic [7:0] left_m1;
	logic [7:0] fv;

	assign left_m1 = left_q - 8'd1;

	// Next walk state for one byte
	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		is_flags_d = is_flags_q;
		held_d     = held_q;
		seen_d     = seen_q;
		over_d     = over_q;
		if (item.has_byte && !over_q) begin
			case (phase_q)
				adf_pkg::PH_LEN: begin
					if (item.data_byte == 8'd0) begin
						over_d = 1'b1;
					end else begin
						left_d  = item.data_byte;
						phase_d = adf_pkg::PH_TYPE;
					end
				end
				adf_pkg::PH_TYPE: begin
					is_flags_d = (item.data_byte == adf_pkg::AD_TYPE_FLAGS) &&
						(left_q >= 8'd2);
					left_d  = left_m1;
					phase_d = (left_m1 == 8'd0) ? adf_pkg::PH_LEN : adf_pkg::PH_VAL_FIRST;
				end
				default: begin
					// value bytes; first one may be the flags byte
					if (phase_q == adf_pkg::PH_VAL_FIRST && is_flags_q) begin
						held_d = item.data_byte;
					end
					left_d = left_m1;
					if (left_m1 == 8'd0) begin
						if (is_flags_q) begin
							seen_d = 1'b1;
							over_d = 1'b1;
						end
						is_flags_d = 1'b0;
						phase_d    = adf_pkg::PH_LEN;
					end else begin
						phase_d = adf_pkg::PH_VAL_REST;
					end
				end
			endcase
		end
	end

	// Verdict from the state after this byte
	always_comb begin
		fv = seen_d ? held_d : 8'd0;
		res.flags_found = seen_d;
		res.flags_value = fv;
		case (mode)
			adf_pkg::MODE_NONE:    res.report_pass = 1'b1;
			adf_pkg::MODE_LIMITED: res.report_pass = seen_d &&
				((fv & adf_pkg::BIT_LIMITED) != 8'd0);
			adf_pkg::MODE_GENERAL: res.report_pass = seen_d &&
				((fv & (adf_pkg::BIT_LIMITED | adf_pkg::BIT_GENERAL)) != 8'd0);
			default:               res.report_pass = 1'b0;
		endcase
	end

	assign res_valid = en && item.last_byte;

	// Walk state; cleared after each report's verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= adf_pkg::PH_LEN;
			left_q     <= 8'd0;
			is_flags_q <= 1'b0;
			held_q     <= 8'd0;
			seen_q     <= 1'b0;
			over_q     <= 1'b0;
		end else if (en) begin
			if (item.last_byte) begin
				phase_q    <= adf_pkg::PH_LEN;
				left_q     <= 8'd0;
				is_flags_q <= 1'b0;
				held_q     <= 8'd0;
				seen_q     <= 1'b0;
				over_q     <= 1'b0;
			end else begin
				phase_q    <= phase_d;
				left_q     <= left_d;
				is_flags_q <= is_flags_d;
				held_q     <= held_d;
				seen_q     <= seen_d;
				over_q     <= over_d;
			end
		end
	end

	// A found flags structure always stops the search
	a_seen_stops: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q |-> over_q)
		else $error("flags seen without search over");

	// Walk state is clear after a verdict
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> (phase_q == adf_pkg::PH_LEN) && !seen_q && !over_q && (left_q == 8'd0))
		else $error("walk state not cleared after verdict");

	// Unknown mode never passes, no-filter mode always passes
	a_mode_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((mode == adf_pkg::MODE_UNKNOWN) ? !res.report_pass :
			((mode == adf_pkg::MODE_NONE) ? res.report_pass : 1'b1)))
		else $error("verdict inconsistent with mode");

endmodule

`default_nettype wire

/* hdl/adf_out_reg.sv */
// Result register with backpressure; drives the pipeline advance.
`default_nettype none

module adf_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             res_valid,
	input  wire adf_pkg::result_t res,
	input  wire logic             out_ready,
	output logic                  out_valid,
	output adf_pkg::result_t      out_res,
	output logic                  advance
);

	// Register may load when empty or being taken
	assign advance = !out_valid || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_res <= res;
		end
	end

endmodule

`default_nettype wire

/* hdl/adv_flags_discovery_filter_top.sv */
// Top level of the advertising flags discovery filter.
`default_nettype none

// Takes one advertising data byte per transaction on the slave stream and, on the
// transaction with tlast set, returns one verdict on the master stream. A transaction
// can be accepted every cycle; the verdict is offered on the master stream once it
// passes from the input register through the walk logic into the result register.
// The input stalls only while a finished verdict waits in the result register.
// tuser low marks a transaction that carries no byte (an empty report when tlast
// is set). discovery_mode is written over the cfg channel, which is always ready;
// the user must write it only while the block is idle; the block does not enforce it.
module adv_flags_discovery_filter_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_data,     // discovery_mode
	// byte stream in
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,      // [7:0] data_byte
	input  wire logic        s_tuser,      // [0] has_byte
	input  wire logic        s_tlast,      // last_byte
	// verdict out
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata       // [0] report_pass, [1] flags_found,
	                                       // [9:2] flags_value, [15:10] zero
);

	logic [1:0]       mode_q;
	adf_pkg::item_t   in_item;
	adf_pkg::item_t   item_s1;
	logic             valid_s1;
	logic             advance;
	logic             res_valid;
	adf_pkg::result_t res;
	adf_pkg::result_t out_res;

	// Mode register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= adf_pkg::MODE_NONE;
		end else if (cfg_valid && cfg_ready) begin
			mode_q <= cfg_data;
		end
	end

	assign in_item = '{data_byte: s_tdata, has_byte: s_tuser, last_byte: s_tlast};

	adf_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_item  (in_item),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	adf_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (valid_s1 && advance),
		.item      (item_s1),
		.mode      (mode_q),
		.res_valid (res_valid),
		.res       (res)
	);

	adf_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_res   (out_res),
		.advance   (advance)
	);

	assign m_tdata = {6'd0, out_res.flags_value, out_res.flags_found, out_res.report_pass};

	// Missing flags means a zero flags byte
	a_no_flags_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tdata[1]) |-> (m_tdata[9:2] == 8'd0))
		else $error("flags value without flags found");

	// Input stalls only behind a held verdict
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled without output backpressure");

endmodule

`default_nettype wire
